// File: hw/rtl/tc_pkg.sv
package tc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int OUT_WIDTH       = 48;
  localparam int STATUS_WIDTH    = 2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_COLLINEAR = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_SAT       = 2'd2;

endpackage

// File: hw/rtl/triangle_circumcenter_core.sv
// Channel   Handshake             Payload
// request   in_valid / in_stall   point_a_x .. point_c_y (signed, COORD_WIDTH each)
// result    out_valid / out_stall center_x, center_y (OUT_WIDTH, FRAC_BITS fraction), status
//
// One request per cycle while no held result stalls the pipeline. The restoring divider
// resolves one quotient bit per pipeline stage.
// rst is synchronous and clears the valid bits, including the skid register's valid bit.
// A held result stalls the whole pipeline; one request is still taken into the skid
// register, and in_stall comes straight from that register.
module triangle_circumcenter_core #(
  parameter int COORD_WIDTH = tc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tc_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_WIDTH-1:0]          point_a_x,
  input  logic signed [COORD_WIDTH-1:0]          point_a_y,
  input  logic signed [COORD_WIDTH-1:0]          point_b_x,
  input  logic signed [COORD_WIDTH-1:0]          point_b_y,
  input  logic signed [COORD_WIDTH-1:0]          point_c_x,
  input  logic signed [COORD_WIDTH-1:0]          point_c_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tc_pkg::OUT_WIDTH-1:0]    center_x,
  output logic signed [tc_pkg::OUT_WIDTH-1:0]    center_y,
  output logic [tc_pkg::STATUS_WIDTH-1:0]        status
);

  localparam int W    = COORD_WIDTH;
  localparam int OW   = tc_pkg::OUT_WIDTH;
  localparam int DW   = W + 1;
  localparam int SQ2W = 2 * W;
  localparam int SQW  = 2 * W + 1;
  localparam int PW   = 2 * DW;
  localparam int DETW = PW + 1;
  localparam int MW   = SQW + DW;
  localparam int NUMW = MW + 1;
  localparam int QW   = NUMW + FRAC_BITS;
  localparam int DENW = DETW + 1;
  localparam int EXTW = QW + OW;

  // skid register
  logic                 skid_valid;
  logic signed [W-1:0]  skid_ax, skid_ay, skid_bx, skid_by, skid_cx, skid_cy;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
    if (!en && !skid_valid) begin
      skid_ax <= point_a_x;
      skid_ay <= point_a_y;
      skid_bx <= point_b_x;
      skid_by <= point_b_y;
      skid_cx <= point_c_x;
      skid_cy <= point_c_y;
    end
  end

  // stage 0: input register
  logic                v0;
  logic signed [W-1:0] ax, ay, bx, by, cx, cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= skid_valid || in_valid;
    end
    if (en) begin
      ax <= skid_valid ? skid_ax : point_a_x;
      ay <= skid_valid ? skid_ay : point_a_y;
      bx <= skid_valid ? skid_bx : point_b_x;
      by <= skid_valid ? skid_by : point_b_y;
      cx <= skid_valid ? skid_cx : point_c_x;
      cy <= skid_valid ? skid_cy : point_c_y;
    end
  end

  // stage 1: squares and differences
  logic                   v1;
  logic signed [SQ2W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [DW-1:0]   dxb1, dyb1, dxc1, dyc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
    if (en) begin
      sq_ax <= ax * ax;
      sq_ay <= ay * ay;
      sq_bx <= bx * bx;
      sq_by <= by * by;
      sq_cx <= cx * cx;
      sq_cy <= cy * cy;
      dxb1  <= DW'(ax) - DW'(bx);
      dyb1  <= DW'(ay) - DW'(by);
      dxc1  <= DW'(ax) - DW'(cx);
      dyc1  <= DW'(ay) - DW'(cy);
    end
  end

  // stage 2: norm differences and determinant products
  logic                  v2;
  logic signed [SQW-1:0] d12, d13;
  logic signed [PW-1:0]  pd1, pd2;
  logic signed [DW-1:0]  dxb2, dyb2, dxc2, dyc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      d12  <= SQW'(sq_ax) + SQW'(sq_ay) - SQW'(sq_bx) - SQW'(sq_by);
      d13  <= SQW'(sq_ax) + SQW'(sq_ay) - SQW'(sq_cx) - SQW'(sq_cy);
      pd1  <= dxb1 * dyc1;
      pd2  <= dxc1 * dyb1;
      dxb2 <= dxb1;
      dyb2 <= dyb1;
      dxc2 <= dxc1;
      dyc2 <= dyc1;
    end
  end

  // stage 3: determinant and numerator products
  logic                   v3;
  logic signed [DETW-1:0] det3;
  logic signed [MW-1:0]   m1, m2, m3, m4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      det3 <= DETW'(pd1) - DETW'(pd2);
      m1   <= d12 * dyc2;
      m2   <= d13 * dyb2;
      m3   <= d12 * dxc2;
      m4   <= d13 * dxb2;
    end
  end

  // stage 4: numerators
  logic                   v4;
  logic signed [DETW-1:0] det4;
  logic signed [NUMW-1:0] nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      det4 <= det3;
      nx   <= NUMW'(m1) - NUMW'(m2);
      ny   <= NUMW'(m3) - NUMW'(m4);
    end
  end

  // stage 5: magnitudes, result signs and collinear flag
  logic            v5, col5, negx5, negy5;
  logic [QW-1:0]   numx5, numy5;
  logic [DENW-1:0] den5;
  logic [NUMW-1:0] magx, magy;
  logic [DETW-1:0] magd;

  always_comb begin
    magx = nx[NUMW-1] ? NUMW'(-nx) : NUMW'(nx);
    magy = ny[NUMW-1] ? NUMW'(-ny) : NUMW'(ny);
    magd = det4[DETW-1] ? DETW'(-det4) : DETW'(det4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      col5  <= (det4 == '0);
      negx5 <= nx[NUMW-1] ^ det4[DETW-1];
      negy5 <= ny[NUMW-1] ^ !det4[DETW-1];
      numx5 <= QW'(magx) << FRAC_BITS;
      numy5 <= QW'(magy) << FRAC_BITS;
      den5  <= DENW'(magd) << 1;
    end
  end

  // divider: one quotient bit per stage, quotient shifts into the numerator register
  logic            dv   [QW];
  logic            dcol [QW];
  logic            dngx [QW];
  logic            dngy [QW];
  logic [QW-1:0]   dnx  [QW];
  logic [QW-1:0]   dny  [QW];
  logic [DENW-1:0] drx  [QW];
  logic [DENW-1:0] dry  [QW];
  logic [DENW-1:0] dden [QW];

  logic            sv   [QW];
  logic            scol [QW];
  logic            sngx [QW];
  logic            sngy [QW];
  logic [QW-1:0]   snx  [QW];
  logic [QW-1:0]   sny  [QW];
  logic [DENW-1:0] srx  [QW];
  logic [DENW-1:0] sry  [QW];
  logic [DENW-1:0] sden [QW];

  logic [QW-1:0]   nnx  [QW];
  logic [QW-1:0]   nny  [QW];
  logic [DENW-1:0] nrx  [QW];
  logic [DENW-1:0] nry  [QW];

  always_comb begin
    sv[0]   = v5;
    scol[0] = col5;
    sngx[0] = negx5;
    sngy[0] = negy5;
    snx[0]  = numx5;
    sny[0]  = numy5;
    srx[0]  = '0;
    sry[0]  = '0;
    sden[0] = den5;
    for (int k = 1; k < QW; k++) begin
      sv[k]   = dv[k-1];
      scol[k] = dcol[k-1];
      sngx[k] = dngx[k-1];
      sngy[k] = dngy[k-1];
      snx[k]  = dnx[k-1];
      sny[k]  = dny[k-1];
      srx[k]  = drx[k-1];
      sry[k]  = dry[k-1];
      sden[k] = dden[k-1];
    end
  end

  always_comb begin
    logic [DENW:0] trx, try_, dfx, dfy;
    for (int k = 0; k < QW; k++) begin
      trx  = {srx[k], snx[k][QW-1]};
      try_ = {sry[k], sny[k][QW-1]};
      dfx  = trx - {1'b0, sden[k]};
      dfy  = try_ - {1'b0, sden[k]};
      nrx[k] = dfx[DENW] ? trx[DENW-1:0] : dfx[DENW-1:0];
      nry[k] = dfy[DENW] ? try_[DENW-1:0] : dfy[DENW-1:0];
      nnx[k] = {snx[k][QW-2:0], !dfx[DENW]};
      nny[k] = {sny[k][QW-2:0], !dfy[DENW]};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QW; k++) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= sv[k];
      end
      if (en) begin
        dcol[k] <= scol[k];
        dngx[k] <= sngx[k];
        dngy[k] <= sngy[k];
        dnx[k]  <= nnx[k];
        dny[k]  <= nny[k];
        drx[k]  <= nrx[k];
        dry[k]  <= nry[k];
        dden[k] <= sden[k];
      end
    end
  end

  // saturate, restore sign, register result
  logic [EXTW-1:0] qxe, qye, limx, limy, valx, valy, resx, resy;
  logic            satx, saty;

  always_comb begin
    qxe  = EXTW'(dnx[QW-1]);
    qye  = EXTW'(dny[QW-1]);
    limx = dngx[QW-1] ? (EXTW'(1) << (OW - 1)) : ((EXTW'(1) << (OW - 1)) - EXTW'(1));
    limy = dngy[QW-1] ? (EXTW'(1) << (OW - 1)) : ((EXTW'(1) << (OW - 1)) - EXTW'(1));
    satx = qxe > limx;
    saty = qye > limy;
    valx = satx ? limx : qxe;
    valy = saty ? limy : qye;
    resx = dngx[QW-1] ? EXTW'(-valx) : valx;
    resy = dngy[QW-1] ? EXTW'(-valy) : valy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QW-1];
    end
    if (en) begin
      if (dcol[QW-1]) begin
        center_x <= '0;
        center_y <= '0;
        status   <= tc_pkg::ST_COLLINEAR;
      end else begin
        center_x <= resx[OW-1:0];
        center_y <= resy[OW-1:0];
        status   <= (satx || saty) ? tc_pkg::ST_SAT : tc_pkg::ST_OK;
      end
    end
  end

  a_col_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == tc_pkg::ST_COLLINEAR |-> center_x == '0 && center_y == '0)
    else $error("collinear result with non-zero centre");

  a_skid_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !en |=> skid_valid)
    else $error("request taken during stall not held in skid register");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == tc_pkg::ST_OK || status == tc_pkg::ST_COLLINEAR ||
                  status == tc_pkg::ST_SAT)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    skid_valid && $past(skid_valid) && !$past(en) |-> $stable(skid_ax) && $stable(skid_cy))
    else $error("skid register changed while held");

endmodule

// File: dv/tb_triangle_circumcenter_core.sv
`timescale 1ns / 100ps

module tb_triangle_circumcenter_core;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [tc_pkg::OUT_WIDTH-1:0] cx;
    logic signed [tc_pkg::OUT_WIDTH-1:0] cy;
    logic [tc_pkg::STATUS_WIDTH-1:0]     st;
  } centre_t;

  class centre_board;
    centre_t pending[$];
    int      errors = 0;

    function logic signed [tc_pkg::OUT_WIDTH-1:0] div_clamp(wide_t num, wide_t den,
                                                            ref bit sat);
      wide_t q;
      wide_t hi_lim;
      wide_t lo_lim;
      hi_lim = (wide_t'(1) <<< (tc_pkg::OUT_WIDTH - 1)) - 1;
      lo_lim = -(wide_t'(1) <<< (tc_pkg::OUT_WIDTH - 1));
      q = (num <<< tc_pkg::FRAC_BITS_DEF) / den;
      if (q > hi_lim) begin
        sat = 1;
        q = hi_lim;
      end else if (q < lo_lim) begin
        sat = 1;
        q = lo_lim;
      end
      return q[tc_pkg::OUT_WIDTH-1:0];
    endfunction

    function void note(coord_t pax, coord_t pay, coord_t pbx, coord_t pby,
                       coord_t pcx, coord_t pcy);
      wide_t ax, ay, bx, by, cx, cy, sa, d12, d13, det, nx, ny;
      centre_t e;
      bit sat;
      ax = pax; ay = pay; bx = pbx; by = pby; cx = pcx; cy = pcy;
      sat = 0;
      sa = ax * ax + ay * ay;
      d12 = sa - (bx * bx + by * by);
      d13 = sa - (cx * cx + cy * cy);
      det = (ax - bx) * (ay - cy) - (ax - cx) * (ay - by);
      if (det == 0) begin
        e.cx = '0;
        e.cy = '0;
        e.st = tc_pkg::ST_COLLINEAR;
      end else begin
        nx = d12 * (ay - cy) - d13 * (ay - by);
        ny = d12 * (ax - cx) - d13 * (ax - bx);
        e.cx = div_clamp(nx, 2 * det, sat);
        e.cy = div_clamp(ny, -2 * det, sat);
        e.st = sat ? tc_pkg::ST_SAT : tc_pkg::ST_OK;
      end
      pending.push_back(e);
    endfunction

    function void check(logic signed [tc_pkg::OUT_WIDTH-1:0] cx,
                        logic signed [tc_pkg::OUT_WIDTH-1:0] cy,
                        logic [tc_pkg::STATUS_WIDTH-1:0] st);
      centre_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %0d %0d %0d", $time, cx, cy, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (cx !== e.cx) begin
        $display("%0t: center_x expected %0d actual %0d", $time, e.cx, cx);
        errors++;
      end
      if (cy !== e.cy) begin
        $display("%0t: center_y expected %0d actual %0d", $time, e.cy, cy);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  coord_t point_a_x = 0, point_a_y = 0, point_b_x = 0, point_b_y = 0;
  coord_t point_c_x = 0, point_c_y = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [tc_pkg::OUT_WIDTH-1:0] center_x, center_y;
  logic [tc_pkg::STATUS_WIDTH-1:0] status;

  centre_board board = new();
  int received = 0;
  int cycles = 0;
  bit quiet_tx = 0;
  bit quiet_rx = 0;

  triangle_circumcenter_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .point_a_x(point_a_x), .point_a_y(point_a_y),
    .point_b_x(point_b_x), .point_b_y(point_b_y),
    .point_c_x(point_c_x), .point_c_y(point_c_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_x(center_x), .center_y(center_y), .status(status)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                              coord_t cx, coord_t cy);
    int gap;
    @(negedge clk);
    point_a_x = ax; point_a_y = ay; point_b_x = bx;
    point_b_y = by; point_c_x = cx; point_c_y = cy;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    board.note(ax, ay, bx, by, cx, cy);
    gap = pick_gap(quiet_tx);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function coord_t rnd_full();
    return coord_t'($urandom);
  endfunction

  function coord_t rnd_small();
    return coord_t'($urandom_range(0, 128)) - 16'sd64;
  endfunction

  task automatic send_random();
    coord_t ax, ay, bx, by, cx, cy;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      ax = rnd_full(); ay = rnd_full(); bx = rnd_full();
      by = rnd_full(); cx = rnd_full(); cy = rnd_full();
    end else if (mode < 7) begin
      ax = rnd_small(); ay = rnd_small(); bx = rnd_small();
      by = rnd_small(); cx = rnd_small(); cy = rnd_small();
    end else begin
      ax = rnd_full(); ay = rnd_full(); bx = rnd_full(); by = rnd_full();
      cx = (ax >>> 1) + (bx >>> 1) + coord_t'($urandom_range(0, 2)) - 16'sd1;
      cy = (ay >>> 1) + (by >>> 1) + coord_t'($urandom_range(0, 2)) - 16'sd1;
    end
    send_request(ax, ay, bx, by, cx, cy);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check(center_x, center_y, status);
      received <= received + 1;
    end
  end

  initial begin
    int hold;
    bit held;
    held = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && received >= 300) begin
        // hold off long enough for the skid register to fill behind the frozen pipeline
        held = 1;
        out_stall = 1;
        repeat (200) @(negedge clk);
        out_stall = 0;
      end else if (quiet_rx) begin
        out_stall = 0;
      end else begin
        hold = pick_gap(0);
        out_stall = (hold > 0);
        if (hold > 1) repeat (hold - 1) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_request(16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000);
    send_request(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(5, 7, 5, 7, 100, -3);
    send_request(1, 1, 2, 2, 3, 3);
    send_request(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 0, 0);
    send_request(0, 0, 4, 0, 0, 4);
    send_request(0, 0, 1, 0, 0, 1);
    send_request(0, 0, 1, 0, 0, -1);
    send_request(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe);
    send_request(-16'sh8000, -16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff);
    send_request(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7ffe, -16'sh7fff);
    send_request(-16'sh8000, 0, 16'sh7fff, 1, 0, 0);
    send_request(0, -16'sh8000, 1, 16'sh7fff, 0, 0);
    send_request(-1, -1, 1, 1, -1, 1);
    send_request(16'sh5555, -16'sh5556, 16'sh2aaa, 16'sh1234, -16'sh0f0f, 16'sh0ff0);
    send_request(3, 0, 0, 4, -3, 0);
    send_request(16'sh7fff, 0, 0, 16'sh7fff, -16'sh8000, 0);

    for (int i = 0; i < 1030; i++) begin
      if (i % 100 == 0) begin
        quiet_tx = ($urandom_range(0, 3) == 0);
        quiet_rx = ($urandom_range(0, 3) == 0);
      end
      send_random();
    end
    @(negedge clk);
    in_valid = 0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
